@@ sv/bhs_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, command and status codes, and types of the bucketed hash set.
// No dependencies; every other file imports this package.
package bhs_pkg;

    // Default geometry of the set
    localparam int DEF_BUCKET_COUNT     = 10;
    localparam int DEF_SLOTS_PER_BUCKET = 8;

    // Payload widths
    localparam int KEY_W = 31;
    localparam int CMD_W = 2;
    localparam int STS_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // Status codes
    localparam logic [STS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL = 2'd2;

    // Decision of the slot update logic
    typedef struct packed {
        logic [STS_W-1:0] status;
        logic             row_we;
    } t_upd_ctl;

    // Valid-bit clearing sweep after reset
    typedef enum logic {
        CLR_SWEEP,
        CLR_DONE
    } t_clr_state;

endpackage

@@ sv/bhs_req_if.sv @@
`timescale 1ns / 1ps
// Request channel of the bucketed hash set: command and key with valid/ready.
// Depends on bhs_pkg.
interface bhs_req_if import bhs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

@@ sv/bhs_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel of the bucketed hash set: one status per request.
// Depends on bhs_pkg.
interface bhs_rsp_if import bhs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [STS_W-1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

@@ sv/bhs_bucket_calc.sv @@
`timescale 1ns / 1ps
// Two pipeline stages that hold the request and reduce the key modulo the bucket count
// by a reciprocal multiply and one multiply-subtract. Depends on bhs_pkg.
module bhs_bucket_calc import bhs_pkg::*; #(
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT
) (
    input  logic             i_clk,
    input  logic             i_s1_load,
    input  logic             i_s2_load,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [KEY_W-1:0] i_key,
    output logic [CMD_W-1:0] o_cmd,
    output logic [KEY_W-1:0] o_key,
    output logic [(BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1)-1:0] o_bucket
);

    localparam int BKT_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int RCP_SH = $clog2(BUCKET_COUNT);
    localparam int RCP_W  = KEY_W + 2;
    localparam int PROD_W = KEY_W + RCP_W;
    // Exact for every key below 2**KEY_W: ceil-style reciprocal with RCP_SH extra bits
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (KEY_W + RCP_SH)) / 64'(BUCKET_COUNT)) + 64'd1;
    localparam logic [RCP_W-1:0] RECIP = RECIP_FULL[RCP_W-1:0];

    logic [CMD_W-1:0]  r1_cmd;
    logic [KEY_W-1:0]  r1_key;
    logic [CMD_W-1:0]  r2_cmd;
    logic [KEY_W-1:0]  r2_key;
    logic [KEY_W-1:0]  r2_quot;
    logic [PROD_W-1:0] w_prod;
    logic [KEY_W-1:0]  n_quot;
    logic [KEY_W-1:0]  w_qd;
    logic [KEY_W-1:0]  w_rem;

    // Stage 1: capture the request
    always_ff @(posedge i_clk) begin
        if (i_s1_load) begin
            r1_cmd <= i_cmd;
            r1_key <= i_key;
        end
    end

    // Quotient by multiplying with the scaled reciprocal
    assign w_prod = PROD_W'(r1_key) * PROD_W'(RECIP);
    assign n_quot = KEY_W'(w_prod >> (KEY_W + RCP_SH));

    // Stage 2: hold the quotient next to the key
    always_ff @(posedge i_clk) begin
        if (i_s2_load) begin
            r2_cmd  <= r1_cmd;
            r2_key  <= r1_key;
            r2_quot <= n_quot;
        end
    end

    // Remainder is the bucket index
    assign w_qd  = r2_quot * KEY_W'(BUCKET_COUNT);
    assign w_rem = r2_key - w_qd;

    assign o_cmd    = r2_cmd;
    assign o_key    = r2_key;
    assign o_bucket = w_rem[BKT_W-1:0];

endmodule

@@ sv/bhs_row_store.sv @@
`timescale 1ns / 1ps
// Bucket row memories (slot keys and slot valid bits) with registered read, write
// forwarding and the valid-bit clearing sweep after reset. Depends on bhs_pkg.
module bhs_row_store import bhs_pkg::*; #(
    parameter int BUCKET_COUNT     = DEF_BUCKET_COUNT,
    parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rd_en,
    input  logic [(BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1)-1:0] i_rd_addr,
    input  logic                                 i_wr_en,
    input  logic [(BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1)-1:0] i_wr_addr,
    input  logic [SLOTS_PER_BUCKET*KEY_W-1:0]    i_wr_keys,
    input  logic [SLOTS_PER_BUCKET-1:0]          i_wr_valid,
    output logic [SLOTS_PER_BUCKET*KEY_W-1:0]    o_rd_keys,
    output logic [SLOTS_PER_BUCKET-1:0]          o_rd_valid,
    output logic                                 o_ready
);

    localparam int BKT_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int ROW_W = SLOTS_PER_BUCKET * KEY_W;

    logic [ROW_W-1:0]            mem_keys  [BUCKET_COUNT];
    logic [SLOTS_PER_BUCKET-1:0] mem_valid [BUCKET_COUNT];

    logic [ROW_W-1:0]            r_rd_keys;
    logic [SLOTS_PER_BUCKET-1:0] r_rd_valid;
    logic                        r_fwd_hit;
    logic [ROW_W-1:0]            r_fwd_keys;
    logic [SLOTS_PER_BUCKET-1:0] r_fwd_valid;

    t_clr_state                  r_clr_state, n_clr_state;
    logic [BKT_W-1:0]            r_clr_addr, n_clr_addr;

    logic                        w_v_we;
    logic [BKT_W-1:0]            w_v_addr;
    logic [SLOTS_PER_BUCKET-1:0] w_v_data;

    // Key rows: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_keys[i_wr_addr] <= i_wr_keys;
        end
        if (i_rd_en) begin
            r_rd_keys <= mem_keys[i_rd_addr];
        end
    end

    // Valid rows: the sweep owns the write port until it is done
    always_comb begin
        if (r_clr_state == CLR_SWEEP) begin
            w_v_we   = 1'b1;
            w_v_addr = r_clr_addr;
            w_v_data = '0;
        end else begin
            w_v_we   = i_wr_en;
            w_v_addr = i_wr_addr;
            w_v_data = i_wr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_v_we) begin
            mem_valid[w_v_addr] <= w_v_data;
        end
        if (i_rd_en) begin
            r_rd_valid <= mem_valid[i_rd_addr];
        end
    end

    // Capture a row written in the same cycle it is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_keys  <= i_wr_keys;
            r_fwd_valid <= i_wr_valid;
        end
    end

    assign o_rd_keys  = r_fwd_hit ? r_fwd_keys  : r_rd_keys;
    assign o_rd_valid = r_fwd_hit ? r_fwd_valid : r_rd_valid;

    // Clearing sweep state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_state <= CLR_SWEEP;
            r_clr_addr  <= '0;
        end else begin
            r_clr_state <= n_clr_state;
            r_clr_addr  <= n_clr_addr;
        end
    end

    // Advance one row per cycle, stop after the last bucket
    always_comb begin
        n_clr_state = r_clr_state;
        n_clr_addr  = r_clr_addr;
        o_ready     = 1'b0;
        case (r_clr_state)
            CLR_SWEEP: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == BKT_W'(BUCKET_COUNT - 1)) begin
                    n_clr_state = CLR_DONE;
                end
            end
            CLR_DONE: begin
                o_ready = 1'b1;
            end
            default: begin
                n_clr_state = CLR_SWEEP;
                n_clr_addr  = '0;
            end
        endcase
    end

    // No row traffic may reach the memories while the sweep runs
    a_sweep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clr_state == CLR_SWEEP) |-> (!i_wr_en && !i_rd_en))
        else $error("row access during clearing sweep");

    // Sweep address stays inside the bucket range
    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clr_state == CLR_SWEEP) |-> (r_clr_addr <= BKT_W'(BUCKET_COUNT - 1)))
        else $error("clearing sweep address out of range");

endmodule

@@ sv/bhs_update.sv @@
`timescale 1ns / 1ps
// Slot compare and update logic: matches the key against one bucket row, picks the
// lowest free slot and forms the status and the new row. Depends on bhs_pkg.
module bhs_update import bhs_pkg::*; #(
    parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
) (
    input  logic [CMD_W-1:0]                  i_cmd,
    input  logic [KEY_W-1:0]                  i_key,
    input  logic [SLOTS_PER_BUCKET*KEY_W-1:0] i_row_keys,
    input  logic [SLOTS_PER_BUCKET-1:0]       i_row_valid,
    output t_upd_ctl                          o_ctl,
    output logic [SLOTS_PER_BUCKET*KEY_W-1:0] o_new_keys,
    output logic [SLOTS_PER_BUCKET-1:0]       o_new_valid
);

    logic [SLOTS_PER_BUCKET-1:0]       w_hit;
    logic [SLOTS_PER_BUCKET-1:0]       w_free;
    logic [SLOTS_PER_BUCKET-1:0]       w_first;
    logic [SLOTS_PER_BUCKET*KEY_W-1:0] w_ins_keys;
    logic                              w_hit_any;
    logic                              w_full;

    // Compare every slot of the row in parallel
    always_comb begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            w_hit[s] = i_row_valid[s] && (i_row_keys[s*KEY_W +: KEY_W] == i_key);
        end
    end

    // Lowest free slot as a one-hot mask
    assign w_free    = ~i_row_valid;
    assign w_first   = w_free & (~w_free + SLOTS_PER_BUCKET'(1));
    assign w_hit_any = |w_hit;
    assign w_full    = ~|w_free;

    // Row with the key placed in the chosen slot
    always_comb begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            w_ins_keys[s*KEY_W +: KEY_W] = w_first[s] ? i_key : i_row_keys[s*KEY_W +: KEY_W];
        end
    end

    // Decide status and row change per command
    always_comb begin
        o_ctl.status = ST_MISS;
        o_ctl.row_we = 1'b0;
        o_new_keys   = i_row_keys;
        o_new_valid  = i_row_valid;
        case (i_cmd)
            CMD_FIND: begin
                o_ctl.status = w_hit_any ? ST_OK : ST_MISS;
            end
            CMD_INSERT: begin
                if (w_hit_any) begin
                    o_ctl.status = ST_MISS;
                end else if (w_full) begin
                    o_ctl.status = ST_FULL;
                end else begin
                    o_ctl.status = ST_OK;
                    o_ctl.row_we = 1'b1;
                    o_new_keys   = w_ins_keys;
                    o_new_valid  = i_row_valid | w_first;
                end
            end
            CMD_DELETE: begin
                if (w_hit_any) begin
                    o_ctl.status = ST_OK;
                    o_ctl.row_we = 1'b1;
                    o_new_valid  = i_row_valid & ~w_hit;
                end
            end
            default: begin
                o_ctl.status = ST_MISS;
            end
        endcase
    end

endmodule

@@ sv/bucketed_hash_set.sv @@
`timescale 1ns / 1ps
// Bucketed hash set: find, insert and delete of 31-bit keys in fixed-size buckets.
// Depends on bhs_pkg, bhs_req_if, bhs_rsp_if, bhs_bucket_calc, bhs_row_store, bhs_update.
//
// Each request transfer (command and key) yields exactly one status transfer, in order.
// The key selects bucket key mod BUCKET_COUNT; all SLOTS_PER_BUCKET slots of that bucket
// are compared at once and an insert takes the lowest free slot. The block sustains one
// request per cycle while the status output is not held up; a request passes through the
// reciprocal multiply, then remainder and row read, then compare and write-back into the
// output register. The row memories have one read and one write port, and a row
// written by one request is forwarded to the request right behind it.
// Stages keep filling while a status waits at the output. After reset the valid bits
// are cleared one bucket row per cycle over all BUCKET_COUNT rows, and no request is
// accepted during that sweep.
module bucketed_hash_set import bhs_pkg::*; #(
    parameter int BUCKET_COUNT     = DEF_BUCKET_COUNT,
    parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bhs_req_if.sink   i_req,
    bhs_rsp_if.source o_rsp
);

    localparam int BKT_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int ROW_W = SLOTS_PER_BUCKET * KEY_W;

    // Stage valid bits and output register
    logic r_v1, r_v2, r_v3, r_out_v;
    logic n_v1, n_v2, n_v3, n_out_v;
    logic [STS_W-1:0] r_out_status;

    // Stage 3 payload
    logic [CMD_W-1:0] r3_cmd;
    logic [KEY_W-1:0] r3_key;
    logic [BKT_W-1:0] r3_bucket;

    // Pipeline movement
    logic w_free_out, w_mv1, w_mv2, w_mv3, w_take1, w_take2, w_take3, w_acc;
    logic w_store_ready;
    logic w_wr_en;

    logic [CMD_W-1:0]            w2_cmd;
    logic [KEY_W-1:0]            w2_key;
    logic [BKT_W-1:0]            w2_bucket;
    logic [ROW_W-1:0]            w_rd_keys;
    logic [SLOTS_PER_BUCKET-1:0] w_rd_valid;
    logic [ROW_W-1:0]            w_new_keys;
    logic [SLOTS_PER_BUCKET-1:0] w_new_valid;
    t_upd_ctl                    w_upd;

    // Advance a stage when the one ahead is empty or moving
    assign w_free_out = !r_out_v || o_rsp.ready;
    assign w_mv3      = r_v3 && w_free_out;
    assign w_take3    = !r_v3 || w_mv3;
    assign w_mv2      = r_v2 && w_take3;
    assign w_take2    = !r_v2 || w_mv2;
    assign w_mv1      = r_v1 && w_take2;
    assign w_take1    = !r_v1 || w_mv1;

    assign i_req.ready = w_take1 && w_store_ready;
    assign w_acc       = i_req.valid && i_req.ready;

    assign n_v1    = w_acc || (r_v1 && !w_mv1);
    assign n_v2    = w_mv1 || (r_v2 && !w_mv2);
    assign n_v3    = w_mv2 || (r_v3 && !w_mv3);
    assign n_out_v = w_mv3 || (r_out_v && !o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_v1    <= n_v1;
            r_v2    <= n_v2;
            r_v3    <= n_v3;
            r_out_v <= n_out_v;
        end
    end

    // Bucket index arithmetic
    bhs_bucket_calc #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_calc (
        .i_clk     (i_clk),
        .i_s1_load (w_acc),
        .i_s2_load (w_mv1),
        .i_cmd     (i_req.command),
        .i_key     (i_req.key),
        .o_cmd     (w2_cmd),
        .o_key     (w2_key),
        .o_bucket  (w2_bucket)
    );

    // Hold the request next to its row read
    always_ff @(posedge i_clk) begin
        if (w_mv2) begin
            r3_cmd    <= w2_cmd;
            r3_key    <= w2_key;
            r3_bucket <= w2_bucket;
        end
    end

    assign w_wr_en = w_mv3 && w_upd.row_we;

    bhs_row_store #(
        .BUCKET_COUNT     (BUCKET_COUNT),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_mv2),
        .i_rd_addr  (w2_bucket),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (r3_bucket),
        .i_wr_keys  (w_new_keys),
        .i_wr_valid (w_new_valid),
        .o_rd_keys  (w_rd_keys),
        .o_rd_valid (w_rd_valid),
        .o_ready    (w_store_ready)
    );

    bhs_update #(
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_update (
        .i_cmd       (r3_cmd),
        .i_key       (r3_key),
        .i_row_keys  (w_rd_keys),
        .i_row_valid (w_rd_valid),
        .o_ctl       (w_upd),
        .o_new_keys  (w_new_keys),
        .o_new_valid (w_new_valid)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_mv3) begin
            r_out_status <= w_upd.status;
        end
    end

    assign o_rsp.valid  = r_out_v;
    assign o_rsp.status = r_out_status;

    // Only inserts and deletes change a row
    a_write_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r3_cmd == CMD_INSERT || r3_cmd == CMD_DELETE))
        else $error("row write from a command that must not modify the set");

    // A row change always reports success
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (o_rsp.valid && o_rsp.status == ST_OK))
        else $error("row write without a success status");

    // A delivered status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.status == ST_OK || o_rsp.status == ST_MISS ||
                         o_rsp.status == ST_FULL))
        else $error("undefined status code");

endmodule

@@ dv/tb_bucketed_hash_set.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of bucketed_hash_set: find/insert/delete traffic with a
// bucket-level predictor and in-order status checking. Depends on bhs_pkg, bhs_req_if,
// bhs_rsp_if and bucketed_hash_set.
module tb_bucketed_hash_set;
    import bhs_pkg::*;

    localparam int BKT       = DEF_BUCKET_COUNT;
    localparam int SLOTS     = DEF_SLOTS_PER_BUCKET;
    localparam int RAND_OPS  = 450;
    localparam int POOL_SIZE = 36;
    localparam int LIMIT     = 200000;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    // Commands outside the defined set (only one is left in two bits)
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
    } set_op_t;

    typedef struct {
        set_op_t          op;
        logic [STS_W-1:0] status;
    } want_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bhs_req_if req_if ();
    bhs_rsp_if rsp_if ();

    bucketed_hash_set i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predicted contents of the set
    logic [KEY_W-1:0] set_key   [BKT*SLOTS];
    logic             set_valid [BKT*SLOTS];

    set_op_t          op_q[$];
    want_t            want_status_q[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    set_op_t     next_op;
    want_t       head;
    logic        req_fire   = 1'b0;
    int          req_done   = 0;
    int          err_cnt    = 0;
    int          cycle_cnt  = 0;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    always #6 i_clk = ~i_clk;

    // Apply one operation to the predicted set and return its status
    function automatic logic [STS_W-1:0] set_apply(logic [CMD_W-1:0] cmd,
                                                   logic [KEY_W-1:0] key);
        int base;
        int hit;
        int free_slot;
        logic [STS_W-1:0] sts;
        base      = int'(key % BKT) * SLOTS;
        hit       = -1;
        free_slot = -1;
        for (int s = 0; s < SLOTS; s++) begin
            if (hit < 0 && set_valid[base+s] && set_key[base+s] == key)
                hit = s;
            if (free_slot < 0 && !set_valid[base+s])
                free_slot = s;
        end
        case (cmd)
            CMD_FIND: begin
                sts = (hit >= 0) ? ST_OK : ST_MISS;
            end
            CMD_INSERT: begin
                if (hit >= 0) begin
                    sts = ST_MISS;
                end else if (free_slot < 0) begin
                    sts = ST_FULL;
                end else begin
                    set_key[base+free_slot]   = key;
                    set_valid[base+free_slot] = 1'b1;
                    sts = ST_OK;
                end
            end
            CMD_DELETE: begin
                if (hit >= 0) begin
                    set_valid[base+hit] = 1'b0;
                    sts = ST_OK;
                end else begin
                    sts = ST_MISS;
                end
            end
            default: begin
                sts = ST_MISS;
            end
        endcase
        return sts;
    endfunction

    task automatic add_op(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
        set_op_t op;
        op.cmd = cmd;
        op.key = key;
        op_q.push_back(op);
    endtask

    // Key in bucket b, small or spread over the whole key range
    function automatic logic [KEY_W-1:0] key_in_bucket(int b, bit wide);
        int unsigned mult;
        mult = wide ? $urandom_range(0, 214748363) : $urandom_range(0, 30);
        return KEY_W'(mult * 10 + b);
    endfunction

    // Sample transfers, predict, check statuses and bound the run
    always @(posedge i_clk) begin
        cycle_cnt++;
        req_fire <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            head.op.cmd = req_if.command;
            head.op.key = req_if.key;
            head.status = set_apply(req_if.command, req_if.key);
            want_status_q.push_back(head);
            req_done <= req_done + 1;
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (want_status_q.size() == 0) begin
                $display("%0t: unexpected status transfer: expected none, got %0d",
                         $time, rsp_if.status);
                err_cnt++;
            end else begin
                head = want_status_q.pop_front();
                if (rsp_if.status !== head.status) begin
                    $display("%0t: status mismatch (cmd %0d key %0d): expected %0d, got %0d",
                             $time, head.op.cmd, head.op.key, head.status, rsp_if.status);
                    err_cnt++;
                end
            end
        end
        if (cycle_cnt >= LIMIT) begin
            $display("%0t: timeout with %0d statuses outstanding", $time,
                     want_status_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // Rotate idling phases every 60 request transfers
    always_comb begin
        case ((req_done / 60) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
    end

    // Drive requests and response ready on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!req_if.valid || req_fire) begin
                if (op_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_op = op_q.pop_front();
                    req_if.valid   <= 1'b1;
                    req_if.command <= next_op.cmd;
                    req_if.key     <= next_op.key;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        int hot[3];
        int roll;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;

        req_if.valid   = 1'b0;
        req_if.command = CMD_FIND;
        req_if.key     = '0;
        rsp_if.ready   = 1'b0;
        for (int i = 0; i < BKT*SLOTS; i++) begin
            set_key[i]   = '0;
            set_valid[i] = 1'b0;
        end

        // Directed: empty set, extremes, duplicates, unused command, full bucket
        add_op(CMD_FIND,   '0);
        add_op(CMD_DELETE, '0);
        add_op(CMD_INSERT, '0);
        add_op(CMD_INSERT, '0);
        add_op(CMD_FIND,   '0);
        add_op(CMD_INSERT, KEY_MAX);
        add_op(CMD_FIND,   KEY_MAX);
        add_op(CMD_UNUSED, '0);
        for (int k = 0; k < SLOTS; k++)
            add_op(CMD_INSERT, KEY_W'(k * 10 + 3));
        add_op(CMD_INSERT, KEY_W'(SLOTS * 10 + 3));
        add_op(CMD_INSERT, KEY_W'(3));
        add_op(CMD_FIND,   KEY_W'(SLOTS * 10 + 3));
        add_op(CMD_DELETE, KEY_W'(33));
        add_op(CMD_INSERT, KEY_W'(SLOTS * 10 + 3));
        add_op(CMD_DELETE, KEY_MAX);
        add_op(CMD_DELETE, KEY_MAX);

        // Concentrate the pool on three buckets so they fill and drain
        for (int h = 0; h < 3; h++)
            hot[h] = $urandom_range(0, BKT - 1);
        for (int p = 0; p < POOL_SIZE; p++)
            key_pool[p] = key_in_bucket(hot[p % 3], p % 2 == 1);

        // Random: mostly pool keys, some fresh keys anywhere in the range
        for (int n = 0; n < RAND_OPS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)      cmd = CMD_INSERT;
            else if (roll < 70) cmd = CMD_FIND;
            else if (roll < 95) cmd = CMD_DELETE;
            else                cmd = CMD_UNUSED;
            roll = $urandom_range(0, 99);
            if (roll < 80)      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (roll < 90) key = key_in_bucket($urandom_range(0, BKT - 1), 1'b1);
            else                key = KEY_W'($urandom);
            add_op(cmd, key);
        end

        // Hold reset, then release on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all requests sent, all statuses returned
        while (op_q.size() != 0 || req_if.valid || want_status_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
